FILE: src/rsf_pkg.sv
// ---------------------------------------------------------------------------
// rsf_pkg
// Shared types and register indexes for the radial shockwave force block.
// ---------------------------------------------------------------------------
package rsf_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_EPICENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPICENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFESPAN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY    = 3'd4;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_JOINT = 1'b1;

   // Command to the iterative square root / divide unit.
   typedef struct packed {
      logic start;
      logic sqrt;
   } rsf_iter_cmd_type;

endpackage

FILE: src/rsf_if.sv
// ---------------------------------------------------------------------------
// rsf_if
// Valid/ready channels of the radial shockwave force block.
// ---------------------------------------------------------------------------
interface rsf_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic        [31:0] time_step;
   logic signed [31:0] joint_x;
   logic signed [31:0] joint_y;
   logic signed [31:0] box_x_min;
   logic signed [31:0] box_x_max;
   logic signed [31:0] box_y_min;
   logic signed [31:0] box_y_max;
   logic               insensitive;

   modport source (output valid, operation, time_step, joint_x, joint_y, box_x_min,
                   box_x_max, box_y_min, box_y_max, insensitive, input ready);
   modport sink   (input valid, operation, time_step, joint_x, joint_y, box_x_min,
                   box_x_max, box_y_min, box_y_max, insensitive, output ready);
endinterface

interface rsf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic               applied;
   logic               alive;

   modport source (output valid, force_x, force_y, applied, alive, input ready);
   modport sink   (input valid, force_x, force_y, applied, alive, output ready);
endinterface

interface rsf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/radial_shockwave_force.sv
// ---------------------------------------------------------------------------
// radial_shockwave_force
// Expanding 2-D shockwave force field in signed fixed point.
// ---------------------------------------------------------------------------
// A tick item on req_ch advances the wave age and radius; a joint item asks
// for the force on one joint. Every item gives one result item on rsp_ch.
// Registers are written on csr_ch, which is always ready; any write of a
// listed register restarts the wave. Writes must happen only while the block
// idles; the block does not enforce it. One item is processed at a time and
// req_ch is not ready while it is busy. A tick passes through S_TMUL and
// S_TUPD to S_OUT. A joint that gets a nonzero-direction force uses three
// squares, the remaining-life product and the two partial products of each
// component on the shared 32x32 multiplier, a square root and two divisions
// in the iterative unit; each component whose quotient saturates skips its
// division. A joint outside the field reaches S_OUT with no root or division.
// The result waits in an output register while rsp_ch stalls; the sequencer
// holds the next result until that register is free. Reset clears the CSRs,
// sets the age and radius to zero and marks the wave alive.
// ---------------------------------------------------------------------------
module radial_shockwave_force #(
   parameter int FRAC_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   rsf_req_if.sink  req_ch,
   rsf_rsp_if.source rsp_ch,
   rsf_csr_if.sink  csr_ch
);
   import rsf_pkg::*;

   localparam int CW  = 64 - FRAC_BITS;
   localparam int NW  = CW + 32;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TMUL   = 4'd1;
   localparam logic [3:0] S_TUPD   = 4'd2;
   localparam logic [3:0] S_JCHK   = 4'd3;
   localparam logic [3:0] S_JSQ1   = 4'd4;
   localparam logic [3:0] S_JSQ2   = 4'd5;
   localparam logic [3:0] S_JCMP   = 4'd6;
   localparam logic [3:0] S_JSQRT  = 4'd7;
   localparam logic [3:0] S_JM0    = 4'd8;
   localparam logic [3:0] S_JM1    = 4'd9;
   localparam logic [3:0] S_JDIV   = 4'd10;
   localparam logic [3:0] S_JDWAIT = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]  state_ff, state_in;

   logic [31:0] epi_x_ff, epi_y_ff, intensity_ff, lifespan_ff, velocity_ff;
   logic [31:0] wave_age_ff, wave_radius_ff;
   logic        wave_alive_ff;

   logic        op_ff, insens_ff;
   logic [31:0] step_ff, jx_ff, jy_ff, bx0_ff, bx1_ff, by0_ff, by1_ff;

   logic [63:0] prod_ff, r2_ff, dx2_ff, lo_ff;
   logic [CW-1:0] c_ff;
   logic [31:0] adx_ff, ady_ff, len_ff;
   logic        negx_ff, negy_ff, comp_ff;
   logic [31:0] fx_ff, fy_ff;
   logic        applied_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_fx_ff, rsp_fy_ff;
   logic        rsp_applied_ff, rsp_alive_ff;

   logic        req_fire, csr_fire, rsp_load;

   // Shared multiplier.
   logic [31:0] mul_a, mul_b;
   logic        mul_en;

   // Geometry.
   logic signed [33:0] ex34, ey34, r34;
   logic               overlap;
   logic signed [32:0] dx, dy;
   logic        [32:0] adx, ady;
   logic               in_square;
   logic [64:0]        f_sum;
   logic [31:0]        rem_life;

   // Tick arithmetic.
   logic [32:0]  age_sum;
   logic [CW:0]  rad_sum;

   // Division setup.
   logic [NW-1:0] num;
   logic [CW-1:0] num_hi;
   logic          quo_big;

   rsf_iter_cmd_type iter_cmd;
   logic        iter_busy, iter_done;
   logic [31:0] iter_result;

   function automatic logic [31:0] sat_force(input logic big, input logic [31:0] q,
                                             input logic neg);
      logic [31:0] v;
      if (neg) begin
         v = (big || q[31]) ? 32'h8000_0000 : (32'd0 - q);
      end else begin
         v = (big || q[31]) ? 32'h7FFF_FFFF : q;
      end
      return v;
   endfunction

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      ex34    = 34'(signed'(epi_x_ff));
      ey34    = 34'(signed'(epi_y_ff));
      r34     = signed'({2'b00, wave_radius_ff});
      overlap = !((ex34 + r34 < 34'(signed'(bx0_ff))) ||
                  (ex34 - r34 > 34'(signed'(bx1_ff))) ||
                  (ey34 + r34 < 34'(signed'(by0_ff))) ||
                  (ey34 - r34 > 34'(signed'(by1_ff))));
      dx  = 33'(signed'(jx_ff)) - 33'(signed'(epi_x_ff));
      dy  = 33'(signed'(jy_ff)) - 33'(signed'(epi_y_ff));
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      in_square = (adx <= {1'b0, wave_radius_ff}) && (ady <= {1'b0, wave_radius_ff});
      f_sum    = {1'b0, dx2_ff} + {1'b0, prod_ff};
      rem_life = (wave_age_ff <= lifespan_ff) ? (lifespan_ff - wave_age_ff) : 32'd0;
      age_sum  = {1'b0, wave_age_ff} + {1'b0, step_ff};
      rad_sum  = {1'b0, prod_ff[63:FRAC_BITS]} + (CW + 1)'(wave_radius_ff);
      num      = {prod_ff[CW-1:0], 32'd0} + NW'(lo_ff);
      num_hi   = num[NW-1:32];
      quo_big  = num_hi >= CW'(len_ff);
   end

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (state_ff)
         S_TMUL: begin
            mul_a = velocity_ff;
            mul_b = step_ff;
         end
         S_JCHK: begin
            mul_a = wave_radius_ff;
            mul_b = wave_radius_ff;
         end
         S_JSQ1: begin
            mul_a = adx_ff;
            mul_b = adx_ff;
         end
         S_JSQ2: begin
            mul_a = ady_ff;
            mul_b = ady_ff;
         end
         S_JCMP: begin
            mul_a = intensity_ff;
            mul_b = rem_life;
         end
         S_JM0: begin
            mul_a = c_ff[31:0];
            mul_b = comp_ff ? ady_ff : adx_ff;
         end
         S_JM1: begin
            mul_a = 32'(c_ff[CW-1:32]);
            mul_b = comp_ff ? ady_ff : adx_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_comb begin
      iter_cmd.sqrt  = (state_ff == S_JCMP);
      iter_cmd.start = ((state_ff == S_JCMP) && (f_sum <= {1'b0, r2_ff}) && (f_sum != '0)) ||
                       ((state_ff == S_JDIV) && !quo_big);
   end

   rsf_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (iter_cmd),
      .radicand (f_sum[63:0]),
      .rem_init (num_hi[31:0]),
      .num_lo   (num[31:0]),
      .den      (len_ff),
      .busy     (iter_busy),
      .done     (iter_done),
      .result   (iter_result)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = (req_ch.operation == OP_TICK) ? S_TMUL : S_JCHK;
         S_TMUL:   state_in = S_TUPD;
         S_TUPD:   state_in = S_OUT;
         S_JCHK:   state_in = (wave_alive_ff && !insens_ff && overlap && in_square) ?
                              S_JSQ1 : S_OUT;
         S_JSQ1:   state_in = S_JSQ2;
         S_JSQ2:   state_in = S_JCMP;
         S_JCMP:   state_in = iter_cmd.start ? S_JSQRT : S_OUT;
         S_JSQRT:  if (iter_done) state_in = S_JM0;
         S_JM0:    state_in = S_JM1;
         S_JM1:    state_in = S_JDIV;
         S_JDIV:   begin
            if (!quo_big) state_in = S_JDWAIT;
            else state_in = comp_ff ? S_OUT : S_JM0;
         end
         S_JDWAIT: if (iter_done) state_in = comp_ff ? S_OUT : S_JM0;
         S_OUT:    if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         epi_x_ff      <= '0;
         epi_y_ff      <= '0;
         intensity_ff  <= '0;
         lifespan_ff   <= '0;
         velocity_ff   <= '0;
         wave_age_ff   <= '0;
         wave_radius_ff <= '0;
         wave_alive_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire && (csr_ch.index <= CSR_VELOCITY)) begin
            unique case (csr_ch.index)
               CSR_EPICENTER_X: epi_x_ff     <= csr_ch.data;
               CSR_EPICENTER_Y: epi_y_ff     <= csr_ch.data;
               CSR_INTENSITY:   intensity_ff <= csr_ch.data;
               CSR_LIFESPAN:    lifespan_ff  <= csr_ch.data;
               default:         velocity_ff  <= csr_ch.data;
            endcase
            wave_age_ff    <= '0;
            wave_radius_ff <= '0;
            wave_alive_ff  <= 1'b1;
         end else if (state_ff == S_TMUL) begin
            wave_age_ff <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
         end else if (state_ff == S_TUPD) begin
            if (wave_age_ff <= lifespan_ff) begin
               wave_radius_ff <= (rad_sum[CW:32] != '0) ? 32'hFFFF_FFFF : rad_sum[31:0];
               wave_alive_ff  <= 1'b1;
            end else begin
               wave_alive_ff <= 1'b0;
            end
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_ch.operation;
         step_ff    <= req_ch.time_step;
         jx_ff      <= req_ch.joint_x;
         jy_ff      <= req_ch.joint_y;
         bx0_ff     <= req_ch.box_x_min;
         bx1_ff     <= req_ch.box_x_max;
         by0_ff     <= req_ch.box_y_min;
         by1_ff     <= req_ch.box_y_max;
         insens_ff  <= req_ch.insensitive;
         fx_ff      <= '0;
         fy_ff      <= '0;
         applied_ff <= 1'b0;
      end
      if (mul_en) prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_JCHK: begin
            adx_ff  <= adx[31:0];
            ady_ff  <= ady[31:0];
            negx_ff <= dx[32];
            negy_ff <= dy[32];
         end
         S_JSQ1: r2_ff  <= prod_ff;
         S_JSQ2: dx2_ff <= prod_ff;
         S_JCMP: if (f_sum <= {1'b0, r2_ff}) applied_ff <= 1'b1;
         S_JSQRT: begin
            c_ff    <= prod_ff[63:FRAC_BITS];
            len_ff  <= iter_result;
            comp_ff <= 1'b0;
         end
         S_JM1: lo_ff <= prod_ff;
         S_JDIV: begin
            if (quo_big) begin
               if (comp_ff) fy_ff <= sat_force(1'b1, '0, negy_ff);
               else fx_ff <= sat_force(1'b1, '0, negx_ff);
               comp_ff <= 1'b1;
            end
         end
         S_JDWAIT: begin
            if (iter_done) begin
               if (comp_ff) fy_ff <= sat_force(1'b0, iter_result, negy_ff);
               else fx_ff <= sat_force(1'b0, iter_result, negx_ff);
               comp_ff <= 1'b1;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_fx_ff      <= fx_ff;
         rsp_fy_ff      <= fy_ff;
         rsp_applied_ff <= applied_ff && (op_ff == OP_JOINT);
         rsp_alive_ff   <= wave_alive_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.force_x = rsp_fx_ff;
   assign rsp_ch.force_y = rsp_fy_ff;
   assign rsp_ch.applied = rsp_applied_ff;
   assign rsp_ch.alive   = rsp_alive_ff;

`ifndef ASSERT_OFF
   a_iter_only_in_joint: assert property (@(posedge clock) disable iff (reset)
      iter_busy |-> (state_ff == S_JSQRT || state_ff == S_JDWAIT))
      else $error("iterative unit busy outside a wait state");

   a_dead_means_old: assert property (@(posedge clock) disable iff (reset)
      !wave_alive_ff |-> (wave_age_ff > lifespan_ff))
      else $error("wave dead while age within lifespan");

   a_no_force_unapplied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_applied_ff) |-> (rsp_fx_ff == '0 && rsp_fy_ff == '0))
      else $error("force given to a joint outside the field");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer did not start on an accepted item");
`endif

endmodule

FILE: src/rsf_iter.sv
// ---------------------------------------------------------------------------
// rsf_iter
// Iterative unit: 64-bit integer square root or 64/32 division, one result
// bit per cycle.
// ---------------------------------------------------------------------------
module rsf_iter (
   input  logic                      clock,
   input  logic                      reset,
   input  rsf_pkg::rsf_iter_cmd_type cmd,
   input  logic [63:0]               radicand,
   input  logic [31:0]               rem_init,
   input  logic [31:0]               num_lo,
   input  logic [31:0]               den,
   output logic                      busy,
   output logic                      done,
   output logic [31:0]               result
);
   import rsf_pkg::*;

   logic        busy_ff, done_ff, sqrt_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] acc_ff, res_ff;
   logic [31:0] sh_ff, den_ff;

   logic [5:0]  bit_pos;
   logic [63:0] bit_v, sum_s;
   logic        ge_s, ge_d;
   logic [32:0] t_d;

   always_comb begin
      bit_pos = 6'd62 - {cnt_ff, 1'b0};
      bit_v   = 64'd1 << bit_pos;
      sum_s   = res_ff + bit_v;
      ge_s    = acc_ff >= sum_s;
      t_d     = {acc_ff[31:0], sh_ff[31]};
      ge_d    = t_d >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sqrt_ff <= cmd.sqrt;
         res_ff  <= '0;
         sh_ff   <= num_lo;
         den_ff  <= den;
         acc_ff  <= cmd.sqrt ? radicand : {32'd0, rem_init};
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            if (ge_s) begin
               acc_ff <= acc_ff - sum_s;
               res_ff <= (res_ff >> 1) + bit_v;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end else begin
            acc_ff <= ge_d ? 64'(t_d - {1'b0, den_ff}) : 64'(t_d);
            res_ff <= {res_ff[62:0], ge_d};
            sh_ff  <= {sh_ff[30:0], 1'b0};
         end
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff[31:0];

endmodule
